[hw/rtl/trl_pkg.sv]
// ----------------------------------------------------------------------------
// trl_pkg: shared types and constants of the tiered route lookup
// Widths, command and status codes, route entry layout and match helpers.
// ----------------------------------------------------------------------------
package trl_pkg;

   localparam int ROUTES_PER_LIST = 32;
   localparam int NUM_LISTS       = 3;
   localparam int NUM_SLOTS       = NUM_LISTS * ROUTES_PER_LIST;
   localparam int ADDR_W          = $clog2(NUM_SLOTS);
   localparam int CNT_W           = $clog2(ROUTES_PER_LIST + 1);
   localparam int RIDX_W          = 7;
   localparam int SUM_W           = (CNT_W + 2 > RIDX_W) ? CNT_W + 2 : RIDX_W;
   localparam int HASH_W          = 32;
   localparam int MCNT_W          = 6;
   localparam int STEP_W          = $clog2(HASH_W);

   typedef enum logic [2:0] {
      CMD_LOOKUP   = 3'd0,
      CMD_ADD_HOST = 3'd1,
      CMD_ADD_NET  = 3'd2,
      CMD_ADD_EXT  = 3'd3,
      CMD_REMOVE   = 3'd4
   } command_type;

   typedef enum logic [1:0] {
      STS_OK       = 2'd0,
      STS_NO_ROUTE = 2'd1,
      STS_FULL     = 2'd2,
      STS_BAD_IDX  = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LK_READ,
      ST_LK_EVAL,
      ST_MOD,
      ST_SEL_READ,
      ST_SEL_EVAL,
      ST_RM_READ,
      ST_RM_WRITE,
      ST_RM_CLEAR
   } state_type;

   localparam logic [1:0] LIST_EXT = 2'd2;

   typedef struct packed {
      logic [31:0] dest;
      logic [31:0] mask;
      logic [31:0] gateway;
      logic [7:0]  iface;
   } route_entry_type;

   typedef struct packed {
      logic            en;
      logic [ADDR_W-1:0] addr;
      route_entry_type data;
   } mem_wr_type;

   function automatic logic [ADDR_W-1:0] slot_addr(input logic [1:0] list,
                                                   input logic [CNT_W-1:0] pos);
      slot_addr = ADDR_W'(list) * ADDR_W'(ROUTES_PER_LIST) + ADDR_W'(pos);
   endfunction

   // Host entries carry an all-ones mask, so one masked compare serves all tiers.
   function automatic logic route_hit(input route_entry_type e,
                                      input logic [31:0] dest,
                                      input logic oif_on,
                                      input logic [7:0] want_if);
      logic hit;
      hit = ((dest & e.mask) == (e.dest & e.mask));
      if (oif_on && (e.iface != want_if)) begin
         hit = 1'b0;
      end
      route_hit = hit;
   endfunction

endpackage

[hw/rtl/trl_route_mem.sv]
// ----------------------------------------------------------------------------
// trl_route_mem: route entry storage
// One write port and one registered read port over all three route lists.
// ----------------------------------------------------------------------------
module trl_route_mem (
   input  logic                      clock,
   input  trl_pkg::mem_wr_type       wr,
   input  logic [trl_pkg::ADDR_W-1:0] rd_addr,
   output trl_pkg::route_entry_type  rd_data
);
   import trl_pkg::*;

   route_entry_type entry_ff [NUM_SLOTS];
   route_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         entry_ff[wr.addr] <= wr.data;
      end
      rd_data_ff <= entry_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/trl_mod_unit.sv]
// ----------------------------------------------------------------------------
// trl_mod_unit: serial modulo unit
// Restoring remainder of the flow hash by the match count, one bit a cycle.
// ----------------------------------------------------------------------------
module trl_mod_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [trl_pkg::HASH_W-1:0] dividend,
   input  logic [trl_pkg::CNT_W-1:0]  divisor,
   output logic                      done,
   output logic [trl_pkg::CNT_W-1:0]  remainder
);
   import trl_pkg::*;

   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [HASH_W-1:0] sh_ff, sh_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  div_ff, div_in;
   logic [CNT_W:0]    trial;

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      step_in = step_ff;
      sh_in   = sh_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      trial   = {rem_ff, sh_ff[HASH_W-1]};
      if (start) begin
         run_in  = 1'b1;
         step_in = '0;
         sh_in   = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (run_ff) begin
         // shift in one hash bit, subtract when the trial reaches the divisor
         if (trial >= {1'b0, div_ff}) begin
            trial = trial - {1'b0, div_ff};
         end
         rem_in  = trial[CNT_W-1:0];
         sh_in   = {sh_ff[HASH_W-2:0], 1'b0};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(HASH_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      sh_ff   <= sh_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

[hw/rtl/tiered_route_lookup_ecmp.sv]
// ----------------------------------------------------------------------------
// tiered_route_lookup_ecmp: three-tier IPv4 route table with ECMP choice
// Host, network and external route lists with add, remove and lookup.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; every request gives
// exactly one response, shown for one cycle with rsp_valid, and the receiver
// cannot stall it. Adds, removes with a bad index and unknown commands answer
// in the cycle after the request and leave busy low. All entries sit in one
// single-port-read memory, so a lookup or remove reads one entry at a time: a
// lookup keeps busy high while it scans the tiers in order (host, then network
// if host is empty of matches, then external up to its first hit), and
// answers in the same cycle that busy drops; with ECMP on and two or more
// matches, the serial modulo of the flow hash picks one match and, unless it
// picks the first, a rescan of the tier finds the chosen match. A remove
// moves each following entry of its list up one slot and clears the last.
// Memory contents after reset are never used before written: list fill
// counts bound every entry that is used, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module tiered_route_lookup_ecmp (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        csr_write_enable,
   input  logic        csr_write_data,
   input  logic [2:0]  req_command,
   input  logic [31:0] req_dest_addr,
   input  logic [31:0] req_mask_bits,
   input  logic [31:0] req_gateway_addr,
   input  logic [7:0]  req_iface,
   input  logic        req_oif_given,
   input  logic [7:0]  req_req_iface,
   input  logic [31:0] req_flow_hash,
   input  logic [6:0]  req_route_index,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_route_dest,
   output logic [31:0] rsp_route_gateway,
   output logic [7:0]  rsp_route_iface,
   output logic [5:0]  rsp_match_count
);
   import trl_pkg::*;

   state_type         state_ff, state_in;
   logic              ecmp_ff;
   logic [1:0]        tier_ff, tier_in;
   logic [CNT_W-1:0]  pos_ff, pos_in;
   logic [CNT_W-1:0]  nmatch_ff, nmatch_in;
   logic [CNT_W-1:0]  seen_ff, seen_in;
   logic [CNT_W-1:0]  sel_ff, sel_in;
   logic [CNT_W-1:0]  counts_ff [NUM_LISTS];
   logic [CNT_W-1:0]  counts_in [NUM_LISTS];
   route_entry_type   hit_ff, hit_in;
   logic [31:0]       dest_ff, dest_in;
   logic              oif_ff, oif_in;
   logic [7:0]        want_ff, want_in;
   logic [HASH_W-1:0] hash_ff, hash_in;

   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   route_entry_type   rsp_entry_ff, rsp_entry_in;
   logic [MCNT_W-1:0] rsp_cnt_ff, rsp_cnt_in;

   mem_wr_type        mem_wr;
   logic [ADDR_W-1:0] mem_rd_addr;
   route_entry_type   mem_rd_data;
   logic              mod_start, mod_done;
   logic [CNT_W-1:0]  mod_rem;

   logic              cur_hit;
   logic              accept;
   logic [1:0]        add_list;
   logic              rm_found;
   logic [1:0]        rm_list;
   logic [CNT_W-1:0]  rm_pos;
   logic [SUM_W-1:0]  rm_r0, rm_r1, rm_r2;
   logic [CNT_W-1:0]  pos_next;

   trl_route_mem u_mem (
      .clock   (clock),
      .wr      (mem_wr),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   trl_mod_unit u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (hash_ff),
      .divisor   (nmatch_ff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && (state_ff == ST_IDLE);
   assign cur_hit  = route_hit(mem_rd_data, dest_ff, oif_ff, want_ff);
   assign add_list = 2'(req_command - 3'd1);
   assign pos_next = pos_ff + 1'b1;

   // Locate the list and position that a remove index falls in.
   always_comb begin
      rm_r0    = SUM_W'(req_route_index);
      rm_r1    = rm_r0 - SUM_W'(counts_ff[0]);
      rm_r2    = rm_r1 - SUM_W'(counts_ff[1]);
      rm_found = 1'b1;
      rm_list  = 2'd0;
      rm_pos   = CNT_W'(rm_r0);
      if (rm_r0 < SUM_W'(counts_ff[0])) begin
         rm_list = 2'd0;
         rm_pos  = CNT_W'(rm_r0);
      end else if (rm_r1 < SUM_W'(counts_ff[1])) begin
         rm_list = 2'd1;
         rm_pos  = CNT_W'(rm_r1);
      end else if (rm_r2 < SUM_W'(counts_ff[2])) begin
         rm_list = 2'd2;
         rm_pos  = CNT_W'(rm_r2);
      end else begin
         rm_found = 1'b0;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_command == CMD_LOOKUP) begin
                  state_in = ST_LK_READ;
               end else if ((req_command == CMD_REMOVE) && rm_found) begin
                  state_in = ST_RM_READ;
               end
            end
         end
         ST_LK_READ: begin
            if (pos_ff < counts_ff[tier_ff]) begin
               state_in = ST_LK_EVAL;
            end else if (nmatch_ff != '0) begin
               state_in = (ecmp_ff && (nmatch_ff > CNT_W'(1))) ? ST_MOD : ST_IDLE;
            end else if (tier_ff == LIST_EXT) begin
               state_in = ST_IDLE;
            end
         end
         ST_LK_EVAL: begin
            state_in = (cur_hit && (tier_ff == LIST_EXT)) ? ST_IDLE : ST_LK_READ;
         end
         ST_MOD: begin
            if (mod_done) begin
               state_in = (mod_rem == '0) ? ST_IDLE : ST_SEL_READ;
            end
         end
         ST_SEL_READ: state_in = ST_SEL_EVAL;
         ST_SEL_EVAL: begin
            state_in = (cur_hit && (seen_ff == sel_ff)) ? ST_IDLE : ST_SEL_READ;
         end
         ST_RM_READ: begin
            state_in = (pos_next < counts_ff[tier_ff]) ? ST_RM_WRITE : ST_RM_CLEAR;
         end
         ST_RM_WRITE: state_in = ST_RM_READ;
         ST_RM_CLEAR: state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Datapath control and register next values.
   always_comb begin
      logic            fin;
      status_type      fin_status;
      route_entry_type fin_entry;
      logic [CNT_W-1:0] fin_cnt;

      fin        = 1'b0;
      fin_status = STS_OK;
      fin_entry  = '0;
      fin_cnt    = '0;

      tier_in   = tier_ff;
      pos_in    = pos_ff;
      nmatch_in = nmatch_ff;
      seen_in   = seen_ff;
      sel_in    = sel_ff;
      counts_in = counts_ff;
      hit_in    = hit_ff;
      dest_in   = dest_ff;
      oif_in    = oif_ff;
      want_in   = want_ff;
      hash_in   = hash_ff;
      mod_start = 1'b0;

      mem_wr      = '0;
      mem_rd_addr = slot_addr(tier_ff, pos_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               dest_in = req_dest_addr;
               oif_in  = req_oif_given;
               want_in = req_req_iface;
               hash_in = req_flow_hash;
               case (req_command)
                  CMD_LOOKUP: begin
                     tier_in   = 2'd0;
                     pos_in    = '0;
                     nmatch_in = '0;
                  end
                  CMD_ADD_HOST, CMD_ADD_NET, CMD_ADD_EXT: begin
                     fin = 1'b1;
                     if (counts_ff[add_list] >= CNT_W'(ROUTES_PER_LIST)) begin
                        fin_status = STS_FULL;
                     end else begin
                        // append at the tail of the list
                        mem_wr.en           = 1'b1;
                        mem_wr.addr         = slot_addr(add_list, counts_ff[add_list]);
                        mem_wr.data.dest    = req_dest_addr;
                        mem_wr.data.mask    = (add_list == 2'd0) ? '1 : req_mask_bits;
                        mem_wr.data.gateway = req_gateway_addr;
                        mem_wr.data.iface   = req_iface;
                        counts_in[add_list] = counts_ff[add_list] + 1'b1;
                     end
                  end
                  CMD_REMOVE: begin
                     if (rm_found) begin
                        tier_in = rm_list;
                        pos_in  = rm_pos;
                     end else begin
                        fin        = 1'b1;
                        fin_status = STS_BAD_IDX;
                     end
                  end
                  default: begin
                     fin = 1'b1;
                  end
               endcase
            end
         end
         ST_LK_READ: begin
            if (pos_ff >= counts_ff[tier_ff]) begin
               if (nmatch_ff != '0) begin
                  if (ecmp_ff && (nmatch_ff > CNT_W'(1))) begin
                     mod_start = 1'b1;
                  end else begin
                     fin       = 1'b1;
                     fin_entry = hit_ff;
                     fin_cnt   = nmatch_ff;
                  end
               end else if (tier_ff == LIST_EXT) begin
                  fin        = 1'b1;
                  fin_status = STS_NO_ROUTE;
               end else begin
                  // no match in this tier: advance to the next one
                  tier_in = tier_ff + 1'b1;
                  pos_in  = '0;
               end
            end
         end
         ST_LK_EVAL: begin
            pos_in = pos_next;
            if (cur_hit) begin
               nmatch_in = nmatch_ff + 1'b1;
               if (nmatch_ff == '0) begin
                  hit_in = mem_rd_data;
               end
               if (tier_ff == LIST_EXT) begin
                  fin       = 1'b1;
                  fin_entry = mem_rd_data;
                  fin_cnt   = CNT_W'(1);
               end
            end
         end
         ST_MOD: begin
            if (mod_done) begin
               sel_in  = mod_rem;
               pos_in  = '0;
               seen_in = '0;
               if (mod_rem == '0) begin
                  fin       = 1'b1;
                  fin_entry = hit_ff;
                  fin_cnt   = nmatch_ff;
               end
            end
         end
         ST_SEL_READ: begin
         end
         ST_SEL_EVAL: begin
            pos_in = pos_next;
            if (cur_hit) begin
               if (seen_ff == sel_ff) begin
                  fin       = 1'b1;
                  fin_entry = mem_rd_data;
                  fin_cnt   = nmatch_ff;
               end else begin
                  seen_in = seen_ff + 1'b1;
               end
            end
         end
         ST_RM_READ: begin
            mem_rd_addr = slot_addr(tier_ff, pos_next);
         end
         ST_RM_WRITE: begin
            // move the following entry up one slot
            mem_wr.en   = 1'b1;
            mem_wr.addr = slot_addr(tier_ff, pos_ff);
            mem_wr.data = mem_rd_data;
            pos_in      = pos_next;
         end
         ST_RM_CLEAR: begin
            mem_wr.en          = 1'b1;
            mem_wr.addr        = slot_addr(tier_ff, counts_ff[tier_ff] - 1'b1);
            mem_wr.data        = '0;
            counts_in[tier_ff] = counts_ff[tier_ff] - 1'b1;
            fin                = 1'b1;
         end
         default: begin
         end
      endcase

      rsp_valid_in  = fin;
      rsp_status_in = rsp_status_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      if (fin) begin
         rsp_status_in = fin_status;
         rsp_entry_in  = fin_entry;
         rsp_cnt_in    = MCNT_W'(fin_cnt);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ecmp_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_LISTS; i++) begin
            counts_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         counts_ff    <= counts_in;
         if (csr_write_enable) begin
            ecmp_ff <= csr_write_data;
         end
      end
      tier_ff       <= tier_in;
      pos_ff        <= pos_in;
      nmatch_ff     <= nmatch_in;
      seen_ff       <= seen_in;
      sel_ff        <= sel_in;
      hit_ff        <= hit_in;
      dest_ff       <= dest_in;
      oif_ff        <= oif_in;
      want_ff       <= want_in;
      hash_ff       <= hash_in;
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_cnt_ff    <= rsp_cnt_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_route_dest    = rsp_entry_ff.dest;
   assign rsp_route_gateway = rsp_entry_ff.gateway;
   assign rsp_route_iface   = rsp_entry_ff.iface;
   assign rsp_match_count   = rsp_cnt_ff;

endmodule

[hw/rtl/trl_checker.sv]
// ----------------------------------------------------------------------------
// trl_checker: port-level checks of the tiered route lookup
// Relates accepted requests to busy and to the responses they produce.
// ----------------------------------------------------------------------------
module trl_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [2:0]  req_command,
   input logic        rsp_valid,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_route_dest,
   input logic [5:0]  rsp_match_count
);
   import trl_pkg::*;

   // an add answers in the next cycle with ok or full and empty route fields
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_command == CMD_ADD_HOST || req_command == CMD_ADD_NET ||
                          req_command == CMD_ADD_EXT))
      |=> rsp_valid && (rsp_status == STS_OK || rsp_status == STS_FULL) &&
          rsp_route_dest == '0 && rsp_match_count == '0)
      else $error("add request did not answer as expected");

   // a lookup always raises busy while it scans
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_command == CMD_LOOKUP) |=> busy)
      else $error("lookup did not raise busy");

   // error and miss responses carry no route
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STS_OK) |-> (rsp_match_count == '0 && rsp_route_dest == '0))
      else $error("error response carries route fields");

   // reset leaves the block idle and quiet
   assert property (@(posedge clock) reset |=> (!busy && !rsp_valid))
      else $error("block not idle after reset");

endmodule

bind tiered_route_lookup_ecmp trl_checker u_trl_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_command     (req_command),
   .rsp_valid       (rsp_valid),
   .rsp_status      (rsp_status),
   .rsp_route_dest  (rsp_route_dest),
   .rsp_match_count (rsp_match_count)
);

[bench/tiered_route_lookup_ecmp_checker.sv]
// ----------------------------------------------------------------------------
// tiered_route_lookup_ecmp_checker: response checker for the route table
// Mirrors the three route lists from observed requests and compares each
// response field by field against the predicted lookup or update outcome.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tiered_route_lookup_ecmp_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic        csr_write_enable,
   input  logic        csr_write_data,
   input  logic [2:0]  req_command,
   input  logic [31:0] req_dest_addr,
   input  logic [31:0] req_mask_bits,
   input  logic [31:0] req_gateway_addr,
   input  logic [7:0]  req_iface,
   input  logic        req_oif_given,
   input  logic [7:0]  req_req_iface,
   input  logic [31:0] req_flow_hash,
   input  logic [6:0]  req_route_index,
   input  logic        rsp_valid,
   input  logic [1:0]  rsp_status,
   input  logic [31:0] rsp_route_dest,
   input  logic [31:0] rsp_route_gateway,
   input  logic [7:0]  rsp_route_iface,
   input  logic [5:0]  rsp_match_count,
   output int          pending_count,
   output int          error_count
);
   import trl_pkg::*;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] dest;
      logic [31:0] gateway;
      logic [7:0]  iface;
      logic [5:0]  hit_count;
   } route_answer_type;

   route_entry_type  table_q [NUM_LISTS][ROUTES_PER_LIST];
   int               fill [NUM_LISTS];
   logic             ecmp_on;
   route_answer_type answers_q [$];

   function automatic logic entry_hits(int lst, int pos, logic [31:0] dst,
                                       logic oif, logic [7:0] want);
      route_entry_type e;
      logic hit;
      e = table_q[lst][pos];
      if (lst == 0) hit = (e.dest == dst);
      else hit = ((dst & e.mask) == (e.dest & e.mask));
      if (oif && e.iface != want) hit = 1'b0;
      return hit;
   endfunction

   // Apply one request to the mirror and return its expected response.
   function automatic route_answer_type route_apply();
      route_answer_type a;
      int lst, n, sel, seen, idx;
      logic done;
      a = '0;
      case (req_command)
         CMD_LOOKUP: begin
            n = 0;
            for (lst = 0; lst < NUM_LISTS && n == 0; lst++) begin
               for (int i = 0; i < fill[lst]; i++) begin
                  if (entry_hits(lst, i, req_dest_addr, req_oif_given, req_req_iface)) begin
                     n++;
                     if (lst == 2) break;
                  end
               end
               if (n != 0) break;
            end
            if (n == 0) begin
               a.status = STS_NO_ROUTE;
            end else begin
               sel = (ecmp_on && n > 1) ? int'(req_flow_hash % 32'(n)) : 0;
               seen = 0;
               for (int i = 0; i < fill[lst]; i++) begin
                  if (entry_hits(lst, i, req_dest_addr, req_oif_given, req_req_iface)) begin
                     if (seen == sel) begin
                        a.dest    = table_q[lst][i].dest;
                        a.gateway = table_q[lst][i].gateway;
                        a.iface   = table_q[lst][i].iface;
                        break;
                     end
                     seen++;
                  end
               end
               a.hit_count = 6'(n);
               a.status    = STS_OK;
            end
         end
         CMD_ADD_HOST, CMD_ADD_NET, CMD_ADD_EXT: begin
            lst = int'(req_command) - 1;
            if (fill[lst] >= ROUTES_PER_LIST) begin
               a.status = STS_FULL;
            end else begin
               table_q[lst][fill[lst]] = '{req_dest_addr,
                  (lst == 0) ? 32'hFFFF_FFFF : req_mask_bits, req_gateway_addr, req_iface};
               fill[lst]++;
            end
         end
         CMD_REMOVE: begin
            idx = req_route_index;
            done = 1'b0;
            for (lst = 0; lst < NUM_LISTS && !done; lst++) begin
               if (idx < fill[lst]) begin
                  for (int i = idx; i + 1 < fill[lst]; i++)
                     table_q[lst][i] = table_q[lst][i+1];
                  table_q[lst][fill[lst]-1] = '0;
                  fill[lst]--;
                  done = 1'b1;
               end else begin
                  idx -= fill[lst];
               end
            end
            if (!done) a.status = STS_BAD_IDX;
         end
         default: ;
      endcase
      return a;
   endfunction

   always @(posedge clock) begin
      route_answer_type exp_a;
      int               errs;
      errs = 0;
      if (reset) begin
         for (int l = 0; l < NUM_LISTS; l++) begin
            fill[l] = 0;
            for (int i = 0; i < ROUTES_PER_LIST; i++) table_q[l][i] = '0;
         end
         ecmp_on = 1'b0;
         answers_q.delete();
         error_count   <= 0;
         pending_count <= 0;
      end else begin
         // check the response first: a same-edge request cannot affect it
         if (rsp_valid) begin
            if (answers_q.size() == 0) begin
               $error("response with no request outstanding");
               errs++;
            end else begin
               exp_a = answers_q.pop_front();
               if (rsp_status !== exp_a.status) begin
                  $error("status exp %0d got %0d", exp_a.status, rsp_status);
                  errs++;
               end
               if (rsp_route_dest !== exp_a.dest) begin
                  $error("route_dest exp %h got %h", exp_a.dest, rsp_route_dest);
                  errs++;
               end
               if (rsp_route_gateway !== exp_a.gateway) begin
                  $error("route_gateway exp %h got %h", exp_a.gateway, rsp_route_gateway);
                  errs++;
               end
               if (rsp_route_iface !== exp_a.iface) begin
                  $error("route_iface exp %0d got %0d", exp_a.iface, rsp_route_iface);
                  errs++;
               end
               if (rsp_match_count !== exp_a.hit_count) begin
                  $error("match_count exp %0d got %0d", exp_a.hit_count, rsp_match_count);
                  errs++;
               end
            end
         end
         if (csr_write_enable) ecmp_on = csr_write_data;
         if (start && !busy) answers_q = {answers_q, route_apply()};
         error_count   <= error_count + errs;
         pending_count <= answers_q.size();
      end
   end

endmodule

[bench/tb_tiered_route_lookup_ecmp.sv]
// ----------------------------------------------------------------------------
// tb_tiered_route_lookup_ecmp: testbench of the tiered route lookup
// Drives directed and random route adds, removes and lookups with random
// gaps, switches flow ECMP between phases, and reports the checker verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_tiered_route_lookup_ecmp;
   import trl_pkg::*;

   localparam int  CYCLE_LIMIT = 2_000_000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        csr_write_enable = 1'b0;
   logic        csr_write_data = 1'b0;
   logic [2:0]  req_command = '0;
   logic [31:0] req_dest_addr = '0;
   logic [31:0] req_mask_bits = '0;
   logic [31:0] req_gateway_addr = '0;
   logic [7:0]  req_iface = '0;
   logic        req_oif_given = 1'b0;
   logic [7:0]  req_req_iface = '0;
   logic [31:0] req_flow_hash = '0;
   logic [6:0]  req_route_index = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_route_dest;
   logic [31:0] rsp_route_gateway;
   logic [7:0]  rsp_route_iface;
   logic [5:0]  rsp_match_count;
   int          pending_count;
   int          error_count;
   int          cycle_count = 0;

   // a small pool of prefixes so lookups hit often and tiers overlap
   logic [31:0] prefix_pool [8];

   always #1 clock = ~clock;

   tiered_route_lookup_ecmp uut (.*);
   tiered_route_lookup_ecmp_checker checker_i (.*);

   // Watchdog: end the run as failed once the cycle count reaches CYCLE_LIMIT.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_tiered_route_lookup_ecmp failed");
         $finish;
      end
   end

   // Issue one request and hold it until the block takes it; start stays
   // high so a request without a gap follows at the next edge.
   task automatic send_request(logic [2:0] cmd, logic [31:0] dst, logic [31:0] msk,
                               logic [31:0] gw, logic [7:0] ifc, logic oif,
                               logic [7:0] want, logic [31:0] hash, logic [6:0] idx);
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start            <= 1'b1;
      req_command      <= cmd;
      req_dest_addr    <= dst;
      req_mask_bits    <= msk;
      req_gateway_addr <= gw;
      req_iface        <= ifc;
      req_oif_given    <= oif;
      req_req_iface    <= want;
      req_flow_hash    <= hash;
      req_route_index  <= idx;
      do @(posedge clock); while (busy);
   endtask

   // Drop start, wait for every response, then let the block settle.
   task automatic drain_and_settle();
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic write_ecmp(logic en);
      drain_and_settle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= en;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Random request: mostly adds and lookups on pool prefixes, some noise.
   task automatic random_request();
      logic [31:0] dst, msk;
      logic [2:0]  cmd;
      int          pick, plen;
      pick = $urandom_range(0, 99);
      if (pick < 45) cmd = CMD_LOOKUP;
      else if (pick < 60) cmd = CMD_ADD_HOST;
      else if (pick < 75) cmd = CMD_ADD_NET;
      else if (pick < 85) cmd = CMD_ADD_EXT;
      else if (pick < 97) cmd = CMD_REMOVE;
      else cmd = 3'($urandom_range(5, 7));
      plen = $urandom_range(0, 32);
      msk = (plen == 0) ? 32'h0 : ~32'h0 << (32 - plen);
      if ($urandom_range(0, 9) == 0) msk = $urandom;
      dst = prefix_pool[$urandom_range(0, 7)];
      if ($urandom_range(0, 2) == 0) dst ^= 32'($urandom_range(0, 255));
      if ($urandom_range(0, 9) == 0) dst = $urandom;
      send_request(cmd, dst, msk, $urandom, 8'($urandom_range(0, 3)),
                   1'($urandom_range(0, 2) == 0), 8'($urandom_range(0, 3)), $urandom,
                   7'($urandom_range(0, 9) == 0 ? $urandom_range(0, 127)
                                                : $urandom_range(0, 40)));
   endtask

   initial begin
      for (int i = 0; i < 8; i++) prefix_pool[i] = $urandom;
      prefix_pool[0] = 32'h0;
      prefix_pool[1] = 32'hFFFF_FFFF;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty lookup, bad remove, field extremes, unknown commands
      send_request(CMD_LOOKUP, 32'h0A00_0001, '0, '0, '0, 1'b0, '0, '0, '0);
      send_request(CMD_REMOVE, '0, '0, '0, '0, 1'b0, '0, '0, 7'd0);
      send_request(CMD_REMOVE, '0, '0, '0, '0, 1'b0, '0, '0, 7'd127);
      send_request(CMD_ADD_HOST, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 8'hFF,
                   1'b0, '0, '0, '0);
      send_request(CMD_ADD_HOST, 32'hFFFF_FFFF, 32'h1234_5678, 32'h0, 8'h00,
                   1'b0, '0, '0, '0);
      send_request(CMD_ADD_NET, 32'h0A00_0000, 32'hFF00_0000, 32'h0A00_00FE, 8'd1,
                   1'b0, '0, '0, '0);
      send_request(CMD_ADD_EXT, 32'h0, 32'h0, 32'hC0A8_0001, 8'd2, 1'b0, '0, '0, '0);
      send_request(CMD_ADD_EXT, 32'h0, 32'h0, 32'hC0A8_0002, 8'd3, 1'b0, '0, '0, '0);
      send_request(CMD_LOOKUP, 32'hFFFF_FFFF, '0, '0, '0, 1'b0, '0, 32'hFFFF_FFFF, '0);
      send_request(CMD_LOOKUP, 32'hFFFF_FFFF, '0, '0, '0, 1'b1, 8'hFF, '0, '0);
      send_request(CMD_LOOKUP, 32'hFFFF_FFFF, '0, '0, '0, 1'b1, 8'd7, '0, '0);
      send_request(CMD_LOOKUP, 32'h0A12_3456, '0, '0, '0, 1'b0, '0, '0, '0);
      send_request(CMD_LOOKUP, 32'h0B00_0000, '0, '0, '0, 1'b1, 8'd3, '0, '0);
      send_request(3'd5, '1, '1, '1, '1, 1'b1, '1, '1, '1);
      send_request(3'd7, '0, '0, '0, '0, 1'b0, '0, '0, '0);
      send_request(CMD_REMOVE, '0, '0, '0, '0, 1'b0, '0, '0, 7'd1);
      send_request(CMD_LOOKUP, 32'hFFFF_FFFF, '0, '0, '0, 1'b0, '0, '0, '0);
      // fill the network list past its capacity
      for (int i = 0; i < ROUTES_PER_LIST + 1; i++)
         send_request(CMD_ADD_NET, 32'h0A00_0000, 32'hFF00_0000, 32'(i), 8'(i % 4),
                      1'b0, '0, '0, '0);
      write_ecmp(1'b1);
      send_request(CMD_LOOKUP, 32'h0A01_0203, '0, '0, '0, 1'b0, '0, 32'hFFFF_FFFF, '0);
      send_request(CMD_LOOKUP, 32'h0A01_0203, '0, '0, '0, 1'b1, 8'd2, 32'd5, '0);
      // remove the first network entry and the first external entry, then drop the rest
      send_request(CMD_REMOVE, '0, '0, '0, '0, 1'b0, '0, '0, 7'd1);
      send_request(CMD_REMOVE, '0, '0, '0, '0, 1'b0, '0, '0, 7'd32);
      for (int i = 0; i < 40; i++)
         send_request(CMD_REMOVE, '0, '0, '0, '0, 1'b0, '0, '0, 7'd0);

      // random phases, alternating the ECMP setting
      for (int ph = 0; ph < 6; ph++) begin
         for (int n = 0; n < 300; n++) random_request();
         if (ph == 2) drain_and_settle();   // sender holds off until all answered
         write_ecmp(ph % 2 == 0 ? 1'b0 : 1'b1);
      end

      drain_and_settle();
      if (error_count == 0) begin
         $display("tb_tiered_route_lookup_ecmp passed");
      end else begin
         $display("tb_tiered_route_lookup_ecmp failed");
      end
      $finish;
   end

endmodule
